@@ design/lzp_pkg.sv @@
// Shared types and constants for the LZP word codec.
// No dependencies; the core takes everything here by scoped names.
`default_nettype none

package lzp_pkg;

    localparam int WORD_W      = 16;
    localparam int TABLE_BITS  = 16;
    localparam int TABLE_DEPTH = 1 << TABLE_BITS;
    localparam int GROUP_LEN   = 16;
    // group position counts 0..GROUP_LEN
    localparam int POS_W       = $clog2(GROUP_LEN + 1);
    // literal buffer index
    localparam int LIT_W       = (GROUP_LEN > 1) ? $clog2(GROUP_LEN) : 1;

    // mode register codes
    localparam logic MODE_DECOMPRESS = 1'b0;
    localparam logic MODE_COMPRESS   = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic              last_of_run;
    } result_t;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_CCMP  = 8'b0000_0100,
        S_CFLAG = 8'b0000_1000,
        S_CLIT  = 8'b0001_0000,
        S_DLIT  = 8'b0010_0000,
        S_DPRED = 8'b0100_0000,
        S_DEMIT = 8'b1000_0000
    } state_t;

endpackage

`default_nettype wire

@@ design/lzp_word_codec_core.sv @@
// LZP word codec core: sequencer, prediction table memory, literal buffer.
// Depends on lzp_pkg for types and constants.
// Compress: each word passes IDLE and CCMP; a flushing word then loads its flag word
// in CFLAG, and CLIT gives one literal a cycle while the output register is free.
// Decompress: a flag word passes IDLE into DPRED, a literal IDLE and DLIT, and each
// predicted word DPRED and DEMIT; output stalls hold both modes. This follows from the
// single table port (registered read) and the one output register.
// Reset: a clearing pass zeroes the table entry by entry; no item meanwhile.
`default_nettype none

module lzp_word_codec_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    // mode write channel
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic            cfg_data,
    // item channel
    input  wire logic            item_valid,
    output logic                 item_stall,
    input  wire lzp_pkg::item_t  item,
    // result channel
    output logic                 result_valid,
    input  wire logic            result_stall,
    output lzp_pkg::result_t     result
);

    localparam int PW = lzp_pkg::POS_W;
    localparam int LW = lzp_pkg::LIT_W;
    localparam int TB = lzp_pkg::TABLE_BITS;
    localparam int WW = lzp_pkg::WORD_W;

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    lzp_pkg::state_t    state_reg, state_next;
    logic [TB-1:0]      clr_addr_reg, clr_addr_next;
    logic               mode_reg, mode_next;
    logic [WW-1:0]      hash_reg, hash_next;
    logic [PW-1:0]      pos_reg, pos_next;
    logic [WW-1:0]      flags_reg, flags_next;
    logic [PW-1:0]      litc_reg, litc_next;
    logic               expect_reg, expect_next;
    logic [PW-1:0]      fidx_reg, fidx_next;
    logic [WW-1:0]      word_reg, word_next;
    logic               last_reg, last_next;
    logic               out_valid_reg, out_valid_next;
    lzp_pkg::result_t   out_data_reg, out_data_next;

    // memory side
    logic [WW-1:0]      pred_mem [lzp_pkg::TABLE_DEPTH];
    logic [WW-1:0]      rd_data_reg;
    logic               mem_we;
    logic [TB-1:0]      mem_waddr;
    logic [WW-1:0]      mem_wdata;
    logic [WW-1:0]      lit_buf [lzp_pkg::GROUP_LEN];
    logic [WW-1:0]      lit_rd_reg;
    logic               lit_we;
    logic [LW-1:0]      lit_widx;

    // helpers
    logic               out_free;
    logic               emit;
    logic [WW-1:0]      emit_word;
    logic               emit_last;
    logic [PW-1:0]      pos_eff;
    logic [PW-1:0]      litc_eff;
    logic [WW-1:0]      flags_eff;
    logic [PW-1:0]      pos_inc;
    logic               cfg_fire;

    // Next hash: shift in four bits and fold the word in.
    function automatic logic [WW-1:0] adv_hash(input logic [WW-1:0] h,
                                               input logic [WW-1:0] w);
        adv_hash = {h[WW-5:0], 4'b0000} ^ w;
    endfunction

    // True when the group still owes a predicted word at position p.
    function automatic logic more_pred(input logic [WW-1:0] f, input logic [PW-1:0] p);
        logic [WW-1:0] sh;
        sh        = f >> p;
        more_pred = (p < PW'(lzp_pkg::GROUP_LEN)) && sh[0];
    endfunction

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign item_stall   = (state_reg != lzp_pkg::S_IDLE);
    assign cfg_ready    = (state_reg == lzp_pkg::S_IDLE) || (state_reg == lzp_pkg::S_CLEAR);
    assign cfg_fire     = cfg_valid && cfg_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;
    // output register can take a new transfer this cycle
    assign out_free     = !out_valid_reg || !result_stall;

    // Group state left over at a full group starts a new group
    assign pos_eff   = (pos_reg >= PW'(lzp_pkg::GROUP_LEN)) ? '0 : pos_reg;
    assign litc_eff  = (pos_reg >= PW'(lzp_pkg::GROUP_LEN)) ? '0 : litc_reg;
    assign flags_eff = (pos_reg >= PW'(lzp_pkg::GROUP_LEN)) ? '0 : flags_reg;
    assign pos_inc   = PW'(pos_reg + 1'b1);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        mode_next     = mode_reg;
        hash_next     = hash_reg;
        pos_next      = pos_reg;
        flags_next    = flags_reg;
        litc_next     = litc_reg;
        expect_next   = expect_reg;
        fidx_next     = fidx_reg;
        word_next     = word_reg;
        last_next     = last_reg;
        mem_we        = 1'b0;
        mem_waddr     = hash_reg[TB-1:0];
        mem_wdata     = word_reg;
        lit_we        = 1'b0;
        lit_widx      = litc_eff[LW-1:0];
        emit          = 1'b0;
        emit_word     = word_reg;
        emit_last     = 1'b0;

        unique case (state_reg)
            lzp_pkg::S_CLEAR:
            begin
                // zero one table entry per cycle
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == '1)
                    state_next = lzp_pkg::S_IDLE;
            end
            lzp_pkg::S_IDLE:
            begin
                if (item_valid)
                begin
                    word_next = item.word;
                    last_next = item.last;
                    if (mode_reg == lzp_pkg::MODE_COMPRESS)
                        state_next = lzp_pkg::S_CCMP;
                    else if (expect_reg)
                    begin
                        // flag word opens a group; no result of its own
                        flags_next  = item.word;
                        pos_next    = '0;
                        expect_next = 1'b0;
                        state_next  = lzp_pkg::S_DPRED;
                    end
                    else
                        state_next = lzp_pkg::S_DLIT;
                end
            end
            lzp_pkg::S_CCMP:
            begin
                // table read for the current hash landed in rd_data_reg
                flags_next = flags_eff;
                litc_next  = litc_eff;
                if (rd_data_reg == word_reg)
                    flags_next = flags_eff | (WW'(1) << pos_eff);
                else
                begin
                    mem_we = 1'b1;
                    if (litc_eff < PW'(lzp_pkg::GROUP_LEN))
                    begin
                        lit_we    = 1'b1;
                        litc_next = PW'(litc_eff + 1'b1);
                    end
                end
                hash_next = adv_hash(hash_reg, word_reg);
                pos_next  = PW'(pos_eff + 1'b1);
                if ((PW'(pos_eff + 1'b1) >= PW'(lzp_pkg::GROUP_LEN)) || last_reg)
                    state_next = lzp_pkg::S_CFLAG;
                else
                    state_next = lzp_pkg::S_IDLE;
            end
            lzp_pkg::S_CFLAG:
            begin
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_word = flags_reg;
                    emit_last = (litc_reg == '0);
                    fidx_next = '0;
                    if (litc_reg == '0)
                    begin
                        pos_next    = '0;
                        flags_next  = '0;
                        expect_next = 1'b1;
                        state_next  = lzp_pkg::S_IDLE;
                    end
                    else
                        state_next = lzp_pkg::S_CLIT;
                end
            end
            lzp_pkg::S_CLIT:
            begin
                // lit_rd_reg holds the literal at fidx_reg
                if (out_free)
                begin
                    emit      = 1'b1;
                    emit_word = lit_rd_reg;
                    emit_last = (PW'(fidx_reg + 1'b1) == litc_reg);
                    fidx_next = PW'(fidx_reg + 1'b1);
                    if (PW'(fidx_reg + 1'b1) == litc_reg)
                    begin
                        pos_next    = '0;
                        flags_next  = '0;
                        litc_next   = '0;
                        expect_next = 1'b1;
                        state_next  = lzp_pkg::S_IDLE;
                    end
                end
            end
            lzp_pkg::S_DLIT:
            begin
                if (out_free)
                begin
                    mem_we     = 1'b1;
                    emit       = 1'b1;
                    emit_word  = word_reg;
                    emit_last  = !more_pred(flags_reg, pos_inc);
                    hash_next  = adv_hash(hash_reg, word_reg);
                    pos_next   = pos_inc;
                    state_next = lzp_pkg::S_DPRED;
                end
            end
            lzp_pkg::S_DPRED:
            begin
                // hash is settled here, so the read for it lands next cycle
                if (more_pred(flags_reg, pos_reg))
                    state_next = lzp_pkg::S_DEMIT;
                else
                begin
                    if ((pos_reg >= PW'(lzp_pkg::GROUP_LEN)) || last_reg)
                    begin
                        pos_next    = '0;
                        flags_next  = '0;
                        litc_next   = '0;
                        expect_next = 1'b1;
                    end
                    state_next = lzp_pkg::S_IDLE;
                end
            end
            lzp_pkg::S_DEMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_word  = rd_data_reg;
                    emit_last  = !more_pred(flags_reg, pos_inc);
                    hash_next  = adv_hash(hash_reg, rd_data_reg);
                    pos_next   = pos_inc;
                    state_next = lzp_pkg::S_DPRED;
                end
            end
            default:
            begin
                state_next = lzp_pkg::S_IDLE;
            end
        endcase

        // mode write: keep table and hash, restart the group
        if (cfg_fire)
        begin
            mode_next   = cfg_data;
            pos_next    = '0;
            flags_next  = '0;
            litc_next   = '0;
            expect_next = 1'b1;
        end
    end

    // Output register: load on emit, drop after the transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next            = 1'b1;
            out_data_next.out_word    = emit_word;
            out_data_next.last_of_run = emit_last;
        end
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lzp_pkg::S_CLEAR;
            clr_addr_reg  <= '0;
            mode_reg      <= lzp_pkg::MODE_DECOMPRESS;
            hash_reg      <= '0;
            pos_reg       <= '0;
            flags_reg     <= '0;
            litc_reg      <= '0;
            expect_reg    <= 1'b1;
            fidx_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            mode_reg      <= mode_next;
            hash_reg      <= hash_next;
            pos_reg       <= pos_next;
            flags_reg     <= flags_next;
            litc_reg      <= litc_next;
            expect_reg    <= expect_next;
            fidx_reg      <= fidx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

    // Prediction table: one write port, one registered read at the current hash
    always_ff @(posedge clk)
    begin
        if (mem_we)
            pred_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= pred_mem[hash_reg[TB-1:0]];
    end

    // Literal buffer for the group being compressed; read ahead at the next index
    always_ff @(posedge clk)
    begin
        if (lit_we)
            lit_buf[lit_widx] <= word_reg;
        lit_rd_reg <= lit_buf[fidx_next[LW-1:0]];
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(lzp_pkg::GROUP_LEN))
        else $error("group position past group length");

    a_lit_le_pos: assert property (@(posedge clk) disable iff (!rst_n)
        litc_reg <= pos_reg)
        else $error("more literals than words in group");

    a_flag_then_lit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lzp_pkg::S_CFLAG) && out_free
        |=> (state_reg == lzp_pkg::S_CLIT) || (state_reg == lzp_pkg::S_IDLE))
        else $error("flag word transfer not followed by literals or idle");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_stall |=> out_valid_reg && $stable(out_data_reg))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

@@ tb/tb_lzp_word_codec_core.sv @@
// Self-checking bench for lzp_word_codec_core: directed and random streams in both modes.
// A local predictor tracks the prediction table, hash and group state at 16-bit words.
// Depends on lzp_pkg for the item and result payload types.
`default_nettype none

module tb_lzp_word_codec_core;

    localparam int WORD_W      = lzp_pkg::WORD_W;
    localparam int TABLE_DEPTH = lzp_pkg::TABLE_DEPTH;
    localparam int GROUP_LEN   = lzp_pkg::GROUP_LEN;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_PCT      = 11;
    // cycles to let a word that owes no result work through the core
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 64;
    // covers the table clearing pass after reset plus the slowest stream, several times
    localparam int LIMIT_CYCLES  = 400_000;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 14;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             cfg_valid    = 1'b0;
    logic             cfg_ready;
    logic             cfg_data     = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    lzp_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    lzp_pkg::result_t result;

    // predictor state
    logic [WORD_W-1:0] dict [TABLE_DEPTH];
    logic [WORD_W-1:0] hash_q;
    int                grp_pos;
    logic [WORD_W-1:0] grp_flags;
    logic [WORD_W-1:0] lits [$];
    bit                awaiting_flags;
    logic              cur_mode;

    // decoded or encoded words still owed by the core, oldest first
    lzp_pkg::result_t owed_words [$];
    int      mismatches = 0;
    // set to hold both sides free of idle cycles
    bit      calm = 1'b0;

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    lzp_word_codec_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    task automatic note_mismatch(input string msg);
        $display("tb mismatch @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int slot_now();
        return int'(hash_q) & (TABLE_DEPTH - 1);
    endfunction

    function automatic void roll(input logic [WORD_W-1:0] w);
        hash_q = {hash_q[WORD_W-5:0], 4'h0} ^ w;
    endfunction

    function automatic void group_restart();
        grp_pos        = 0;
        grp_flags      = '0;
        lits.delete();
        awaiting_flags = 1'b1;
    endfunction

    // Work out the words one accepted item causes and queue them.
    function automatic void codec_step(input lzp_pkg::item_t it);
        logic [WORD_W-1:0] words [$];
        logic [WORD_W-1:0] w;
        lzp_pkg::result_t  r;
        int                s;
        s = slot_now();
        if (cur_mode == lzp_pkg::MODE_COMPRESS)
        begin
            if (grp_pos >= GROUP_LEN)
                group_restart();
            if (dict[s] == it.word)
                grp_flags[grp_pos] = 1'b1;
            else
            begin
                dict[s] = it.word;
                if (lits.size() < GROUP_LEN)
                    lits.push_back(it.word);
            end
            roll(it.word);
            grp_pos++;
            // flush the flag word and the literals at a full group or stream end
            if (grp_pos >= GROUP_LEN || it.last)
            begin
                words.push_back(grp_flags);
                foreach (lits[k])
                    words.push_back(lits[k]);
                group_restart();
            end
        end
        else
        begin
            if (awaiting_flags)
            begin
                grp_flags      = it.word;
                grp_pos        = 0;
                awaiting_flags = 1'b0;
            end
            else
            begin
                dict[s] = it.word;
                words.push_back(it.word);
                roll(it.word);
                grp_pos++;
            end
            // emit predicted words up to the next clear flag bit
            while (grp_pos < GROUP_LEN && grp_flags[grp_pos])
            begin
                w = dict[slot_now()];
                words.push_back(w);
                roll(w);
                grp_pos++;
            end
            if (grp_pos >= GROUP_LEN || it.last)
                group_restart();
        end
        foreach (words[k])
        begin
            r.out_word    = words[k];
            r.last_of_run = (k == words.size() - 1);
            owed_words.push_back(r);
        end
    endfunction

    // Offer one word, hold it until the transfer, then predict.
    task automatic send_word(input logic [WORD_W-1:0] w, input logic lst);
        lzp_pkg::item_t it;
        it.word = w;
        it.last = lst;
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        codec_step(it);
    endtask

    // Drop valid, wait for every owed word, then let the core go quiet.
    task automatic settle(input int hold);
        item_valid <= 1'b0;
        while (owed_words.size() != 0)
            @(posedge clk);
        repeat (hold) @(posedge clk);
    endtask

    task automatic write_mode(input logic m);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cur_mode = m;
        group_restart();
    endtask

    // Result side: check each transfer against the oldest owed word, stall at random.
    always @(posedge clk)
    begin : check_results
        lzp_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (owed_words.size() == 0)
                note_mismatch($sformatf("unexpected result %h", result));
            else
            begin
                want = owed_words.pop_front();
                if (result.out_word !== want.out_word)
                    note_mismatch($sformatf("out_word %h, want %h",
                                            result.out_word, want.out_word));
                if (result.last_of_run !== want.last_of_run)
                    note_mismatch($sformatf("last_of_run %b, want %b on word %h",
                                            result.last_of_run, want.last_of_run,
                                            want.out_word));
            end
        end
        result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Reset leaves the core decompressing; cover empty runs, full runs and stream ends.
    task automatic test_decompress_at_reset();
        send_word(16'h0000, 1'b0);      // lowest flag bit clear: nothing comes out
        send_word(16'hFFFF, 1'b0);
        send_word(16'h0000, 1'b1);      // stream ends at a literal
        send_word(16'hFFFF, 1'b0);      // whole group predicted
        send_word(16'h00FF, 1'b1);      // stream ends at the flag word itself
        send_word(16'h0FFE, 1'b0);
        send_word(16'h8001, 1'b1);      // words still owed after the last literal
        send_word(16'hFFFE, 1'b0);
        send_word(16'h1234, 1'b0);
        settle(SETTLE_CYCLES);
    endtask

    task automatic test_compress_extremes();
        logic [WORD_W-1:0] pattern [16];
        pattern = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                    16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'h0000, 16'h0000, 16'h5555, 16'hAAAA};
        write_mode(lzp_pkg::MODE_COMPRESS);
        send_word(16'h0000, 1'b1);      // one-word stream that hits the zeroed table
        foreach (pattern[i])
            send_word(pattern[i], 1'b0);    // full group flushes on its own
        settle(SETTLE_CYCLES);
    endtask

    // Data words drawn mostly from a short repeating motif so predictions hit.
    task automatic random_compress(input int n);
        logic [WORD_W-1:0] motif [8];
        logic [WORD_W-1:0] w;
        logic              lst;
        int                mlen;
        int                k;
        mlen = $urandom_range(2, 8);
        foreach (motif[i])
            motif[i] = WORD_W'($urandom_range(16'hFFFF));
        k = 0;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 70)
            begin
                w = motif[k % mlen];
                k++;
            end
            else
                w = WORD_W'($urandom_range(16'hFFFF));
            // the phase may end mid-group; the next mode write clears it
            lst = (i == n - 1) ? 1'($urandom_range(1)) : ($urandom_range(11) == 0);
            send_word(w, lst);
        end
    endtask

    // Mostly a flag word with one literal per clear bit; some streams cut short, some noise.
    task automatic random_decompress(input int n);
        logic [WORD_W-1:0] flags;
        logic              lst;
        int                sent;
        int                kind;
        int                need;
        int                cut;
        sent = 0;
        while (sent < n)
        begin
            kind = $urandom_range(9);
            if (kind == 9)
            begin
                send_word(WORD_W'($urandom_range(16'hFFFF)), $urandom_range(3) == 0);
                sent++;
            end
            else
            begin
                if (kind < 6)
                    flags = WORD_W'($urandom_range(16'hFFFF) | $urandom_range(16'hFFFF));
                else
                    flags = WORD_W'($urandom_range(16'hFFFF));
                need = 0;
                for (int b = 0; b < WORD_W; b++)
                    if (!flags[b])
                        need++;
                cut = (kind == 8) ? $urandom_range(need) : need;
                lst = (cut == 0) && (kind == 8 || $urandom_range(1) == 1);
                send_word(flags, lst);
                for (int j = 1; j <= cut; j++)
                    send_word(WORD_W'($urandom_range(16'hFFFF)),
                              (j == cut) && (kind == 8 || $urandom_range(2) == 0));
                sent += 1 + cut;
            end
        end
    endtask

    task automatic test_random_streams();
        logic m;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            calm = (ph == 3);
            m = (ph % 2 == 0) ? lzp_pkg::MODE_DECOMPRESS : lzp_pkg::MODE_COMPRESS;
            write_mode(m);
            if (m == lzp_pkg::MODE_COMPRESS)
                random_compress(PHASE_ITEMS);
            else
                random_decompress(PHASE_ITEMS);
            settle(SETTLE_CYCLES);
            calm = 1'b0;
        end
    endtask

    initial
    begin
        foreach (dict[i])
            dict[i] = '0;
        hash_q   = '0;
        cur_mode = lzp_pkg::MODE_DECOMPRESS;
        group_restart();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_decompress_at_reset();
        test_compress_extremes();
        test_random_streams();

        settle(DRAIN_CYCLES);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
